FILE: hdl/camera_view_selector_top_defines.svh
// Assertion macros shared by the camera view selector RTL.
`ifndef CAMERA_VIEW_SELECTOR_TOP_DEFINES_SVH
`define CAMERA_VIEW_SELECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CVS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define CVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CVS_ASSERT_ALWAYS(lbl, cond, msg)
`define CVS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/cvs_pkg.sv
// Types and constants of the camera view selector.
`default_nettype none
package cvs_pkg;
    typedef logic [31:0] t_word;
    typedef logic [63:0] t_prod;

    localparam int VIEW_W = 10;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_COS    = 2'd1;
    localparam logic [1:0] CFG_START  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FALLBACK = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [30:0]       RADIUS_RST = 31'd98304000;
    localparam logic [15:0]       COS_RST    = 16'd62259;
    localparam logic [VIEW_W-1:0] START_RST  = 10'd10;
endpackage
`default_nettype wire

FILE: hdl/cvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cvs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/cvs_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none
module cvs_mul (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire cvs_pkg::t_word i_a,
    input  wire cvs_pkg::t_word i_b,
    output cvs_pkg::t_prod      o_prod
);
    import cvs_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= t_prod'(i_a) * t_prod'(i_b);
        end
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

FILE: hdl/camera_view_selector_top.sv
// Camera view selector: pose table, nearest-camera search and view filter.
//
// Input stream (s_axis): tuser is the operation (0 load pose, 1 query), tdata the
// eye and look points. A load appends a pose and answers with the slot it wrote,
// or status full. A query answers with the selected view and a status.
// Output stream (m_axis): tdata the view index, tuser the status.
// Config channel: index 0 radius, 1 cosine threshold, 2 start view; always ready.
// Only one transaction is worked on at a time. A query first scales the viewer
// direction, then runs the nearest search over the N stored poses and a second
// pass over them: a pose outside the radius costs only its distance products,
// one inside it iterative direction scaling and up to 15 products. Every
// product goes through the one shared 32x32 multiplier; that unit sets the rate.
// The result waits in an output register; the next transaction is accepted while
// it waits, but its own result is held until the receiver takes the first.
// Reset empties the table, restores the registers and sets the current view to
// the start view. The pose memories are not cleared; only entries below the
// fill count are ever read.
`default_nettype none
`include "camera_view_selector_top_defines.svh"
module camera_view_selector_top #(
    parameter int MAX_VIEWS = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // eye_x, eye_y, eye_z, look_x, look_y, look_z (32 bits each)
    input  wire logic [191:0] i_s_axis_tdata,
    // operation
    input  wire logic [0:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // view_index [9:0], zero fill
    output logic [15:0]       o_m_axis_tdata,
    // status
    output logic [1:0]        o_m_axis_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [30:0]  i_cfg_data
);
    import cvs_pkg::*;

    localparam int IDX_W = $clog2(MAX_VIEWS);
    localparam int CNT_W = $clog2(MAX_VIEWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_VLOAD, S_SCALE, S_OPND, S_MUL, S_ACC, S_RD, S_NEXT, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        U_VNORM, U_THR2, U_NT, U_R2, U_DN, U_DR, U_NC, U_DOT, U_D2, U_PL, U_PH, U_DF
    } t_uop;

    function automatic logic signed [31:0] dsat(logic signed [31:0] e,
                                               logic signed [31:0] l);
        logic signed [32:0] d;
        d = {l[31], l} - {e[31], e};
        if (d[32] != d[31]) begin
            return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return d[31:0];
    endfunction

    function automatic t_word dmag(logic signed [31:0] a, logic signed [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (~d + 33'd1) : d;
        if (m[32] || (m[31] && (|m[30:0]))) begin
            return 32'h8000_0000;
        end
        return m[31:0];
    endfunction

    function automatic t_word mag32(logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    t_state r_state;
    t_uop   r_uop;
    logic [1:0]          r_k;
    logic signed [31:0]  r_qeye [3];
    logic signed [31:0]  r_qdir [3];
    logic signed [31:0]  r_neye [3];
    t_word               r_smag [3];
    logic [2:0]          r_csgn;
    logic [14:0]         r_vmag [3];
    logic [2:0]          r_vsgn;
    logic                r_scl_cam;
    logic                r_pass;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_best;
    logic                r_found;
    logic [63:0]         r_bestd;
    logic [VIEW_W-1:0]   r_cur;
    logic                r_seen;
    logic [30:0]         r_radius;
    logic [15:0]         r_cos;
    t_word               r_nv;
    t_word               r_thr2;
    t_prod               r_nt;
    logic [61:0]         r_r2;
    t_word               r_nc;
    logic signed [33:0]  r_dot;
    t_prod               r_d2;
    t_prod               r_plo;
    t_prod               r_acc;
    t_word               r_opa;
    t_word               r_opb;
    logic                r_opsgn;
    logic [VIEW_W-1:0]   r_res_idx;
    logic [1:0]          r_res_st;
    logic                r_out_valid;
    logic [VIEW_W-1:0]   r_out_idx;
    logic [1:0]          r_out_status;

    logic [95:0]         w_eye_rd;
    logic [95:0]         w_dir_rd;
    logic signed [31:0]  w_ceye [3];
    logic signed [31:0]  w_cdir [3];
    t_prod               w_prod;
    t_prod               n_acc;
    logic signed [33:0]  n_dot;
    logic [95:0]         w_rhs;
    logic                w_last_k;
    logic                w_last_entry;
    logic                w_big;
    t_word               w_dm;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_ceye[j] = w_eye_rd[j*32 +: 32];
            w_cdir[j] = w_dir_rd[j*32 +: 32];
        end
    end

    assign n_acc = ((r_k == 2'd0) ? 64'd0 : r_acc) + w_prod;
    assign n_dot = ((r_k == 2'd0) ? 34'sd0 : r_dot)
                 + (r_opsgn ? -$signed({2'b00, w_prod[31:0]}) : $signed({2'b00, w_prod[31:0]}));
    assign w_rhs = {w_prod[63:0], 32'd0} + {32'd0, r_plo};
    assign w_last_k = (r_k == 2'd2);
    assign w_last_entry = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign w_big = |(r_smag[0][31:15] | r_smag[1][31:15] | r_smag[2][31:15]);
    assign w_dm = dmag((r_uop == U_DR) ? r_neye[r_k] : r_qeye[r_k], w_ceye[r_k]);

    cvs_ram #(.WIDTH(96), .DEPTH(MAX_VIEWS)) u_eye_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_qeye[2], r_qeye[1], r_qeye[0]}),
        .i_raddr (r_idx),
        .o_rdata (w_eye_rd)
    );

    cvs_ram #(.WIDTH(96), .DEPTH(MAX_VIEWS)) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({r_qdir[2], r_qdir[1], r_qdir[0]}),
        .i_raddr (r_idx),
        .o_rdata (w_dir_rd)
    );

    cvs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (r_state == S_MUL),
        .i_a    (r_opa),
        .i_b    (r_opb),
        .o_prod (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur       <= START_RST;
            r_radius    <= RADIUS_RST;
            r_cos       <= COS_RST;
            r_seen      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_out_valid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_COS:    r_cos    <= i_cfg_data[15:0];
                    CFG_START: begin
                        if (!r_seen) begin
                            r_cur <= i_cfg_data[VIEW_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        for (int j = 0; j < 3; j++) begin
                            r_qeye[j] <= i_s_axis_tdata[j*32 +: 32];
                            r_qdir[j] <= dsat(i_s_axis_tdata[j*32 +: 32],
                                              i_s_axis_tdata[(j+3)*32 +: 32]);
                        end
                        if (i_s_axis_tuser[0] == OP_LOAD) begin
                            if (r_count >= CNT_W'(MAX_VIEWS)) begin
                                r_res_idx <= '0;
                                r_res_st  <= ST_FULL;
                                r_state   <= S_DONE;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_seen <= 1'b1;
                            if (r_count == '0) begin
                                r_res_idx <= r_cur;
                                r_res_st  <= ST_EMPTY;
                                r_state   <= S_DONE;
                            end else begin
                                r_state <= S_VLOAD;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_res_idx <= VIEW_W'(r_count);
                    r_res_st  <= ST_OK;
                    r_count   <= r_count + CNT_W'(1);
                    r_state   <= S_DONE;
                end
                S_VLOAD: begin
                    for (int j = 0; j < 3; j++) begin
                        r_smag[j] <= mag32(r_qdir[j]);
                        r_csgn[j] <= r_qdir[j][31];
                    end
                    r_scl_cam <= 1'b0;
                    r_state   <= S_SCALE;
                end
                S_SCALE: begin
                    // common right shift until every magnitude is below 2^15
                    if (w_big) begin
                        for (int j = 0; j < 3; j++) begin
                            r_smag[j] <= r_smag[j] >> 1;
                        end
                    end else begin
                        r_k     <= 2'd0;
                        r_state <= S_OPND;
                        if (r_scl_cam) begin
                            r_uop <= U_NC;
                        end else begin
                            for (int j = 0; j < 3; j++) begin
                                r_vmag[j] <= r_smag[j][14:0];
                            end
                            r_vsgn <= r_csgn;
                            r_uop  <= U_VNORM;
                        end
                    end
                end
                S_OPND: begin
                    r_opsgn <= 1'b0;
                    case (r_uop)
                        U_VNORM: begin
                            r_opa <= t_word'(r_vmag[r_k]);
                            r_opb <= t_word'(r_vmag[r_k]);
                        end
                        U_THR2: begin
                            r_opa <= t_word'(r_cos);
                            r_opb <= t_word'(r_cos);
                        end
                        U_NT: begin
                            r_opa <= r_nv;
                            r_opb <= r_thr2;
                        end
                        U_R2: begin
                            r_opa <= t_word'(r_radius);
                            r_opb <= t_word'(r_radius);
                        end
                        U_NC: begin
                            r_opa <= t_word'(r_smag[r_k][14:0]);
                            r_opb <= t_word'(r_smag[r_k][14:0]);
                        end
                        U_DOT: begin
                            r_opa   <= t_word'(r_smag[r_k][14:0]);
                            r_opb   <= t_word'(r_vmag[r_k]);
                            r_opsgn <= r_csgn[r_k] ^ r_vsgn[r_k];
                        end
                        U_D2: begin
                            r_opa <= r_dot[31:0];
                            r_opb <= r_dot[31:0];
                        end
                        U_PL: begin
                            r_opa <= r_nc;
                            r_opb <= r_nt[31:0];
                        end
                        U_PH: begin
                            r_opa <= r_nc;
                            r_opb <= r_nt[63:32];
                        end
                        default: begin
                            r_opa <= w_dm;
                            r_opb <= w_dm;
                        end
                    endcase
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= n_acc;
                    r_dot   <= n_dot;
                    case (r_uop)
                        U_VNORM: begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_OPND;
                            if (w_last_k) begin
                                r_nv  <= n_acc[31:0];
                                r_uop <= U_THR2;
                            end
                        end
                        U_THR2: begin
                            r_thr2  <= w_prod[31:0];
                            r_uop   <= U_NT;
                            r_state <= S_OPND;
                        end
                        U_NT: begin
                            r_nt    <= w_prod;
                            r_uop   <= U_R2;
                            r_state <= S_OPND;
                        end
                        U_R2: begin
                            r_r2    <= w_prod[61:0];
                            r_pass  <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end
                        U_DN: begin
                            r_k <= r_k + 2'd1;
                            if (w_last_k) begin
                                if ((r_idx == '0) || (n_acc < r_bestd)) begin
                                    r_bestd <= n_acc;
                                    r_best  <= r_idx;
                                    for (int j = 0; j < 3; j++) begin
                                        r_neye[j] <= w_ceye[j];
                                    end
                                end
                                r_state <= S_NEXT;
                            end else begin
                                r_state <= S_OPND;
                            end
                        end
                        U_DR: begin
                            r_k <= r_k + 2'd1;
                            if (w_last_k) begin
                                if (n_acc < t_prod'(r_r2)) begin
                                    for (int j = 0; j < 3; j++) begin
                                        r_smag[j] <= mag32(w_cdir[j]);
                                        r_csgn[j] <= w_cdir[j][31];
                                    end
                                    r_scl_cam <= 1'b1;
                                    r_state   <= S_SCALE;
                                end else begin
                                    r_state <= S_NEXT;
                                end
                            end else begin
                                r_state <= S_OPND;
                            end
                        end
                        U_NC: begin
                            r_state <= S_OPND;
                            if (w_last_k) begin
                                r_nc  <= n_acc[31:0];
                                r_uop <= U_DOT;
                                r_k   <= 2'd0;
                            end else begin
                                r_k <= r_k + 2'd1;
                            end
                        end
                        U_DOT: begin
                            r_k <= r_k + 2'd1;
                            if (w_last_k) begin
                                if ((n_dot <= 34'sd0) || (r_nc == '0) || (r_nv == '0)) begin
                                    r_state <= S_NEXT;
                                end else begin
                                    r_uop   <= U_D2;
                                    r_state <= S_OPND;
                                end
                            end else begin
                                r_state <= S_OPND;
                            end
                        end
                        U_D2: begin
                            r_d2    <= w_prod;
                            r_uop   <= U_PL;
                            r_state <= S_OPND;
                        end
                        U_PL: begin
                            r_plo   <= w_prod;
                            r_uop   <= U_PH;
                            r_state <= S_OPND;
                        end
                        U_PH: begin
                            if ({r_d2, 32'd0} > w_rhs) begin
                                r_uop   <= U_DF;
                                r_k     <= 2'd0;
                                r_state <= S_OPND;
                            end else begin
                                r_state <= S_NEXT;
                            end
                        end
                        U_DF: begin
                            r_k <= r_k + 2'd1;
                            if (w_last_k) begin
                                if (!r_found || (n_acc < r_bestd)) begin
                                    r_found <= 1'b1;
                                    r_bestd <= n_acc;
                                    r_best  <= r_idx;
                                end
                                r_state <= S_NEXT;
                            end else begin
                                r_state <= S_OPND;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RD: begin
                    // read data for r_idx is valid from the next cycle on
                    r_k     <= 2'd0;
                    r_uop   <= r_pass ? U_DR : U_DN;
                    r_state <= S_OPND;
                end
                S_NEXT: begin
                    if (!w_last_entry) begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RD;
                    end else if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_RD;
                    end else begin
                        if (r_found) begin
                            r_cur     <= VIEW_W'(r_best);
                            r_res_idx <= VIEW_W'(r_best);
                            r_res_st  <= ST_OK;
                        end else begin
                            r_res_idx <= r_cur;
                            r_res_st  <= ST_FALLBACK;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_idx    <= r_res_idx;
                        r_out_status <= r_res_st;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 16'(r_out_idx);
    assign o_m_axis_tuser  = r_out_status;
    assign o_cfg_ready     = 1'b1;

    `CVS_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(MAX_VIEWS), "entry count above table size")
    `CVS_ASSERT_NEXT(a_count_only_on_load, r_state != S_LOAD, $stable(r_count), "entry count moved outside a load")
    `CVS_ASSERT_ALWAYS(a_best_stored, !r_found || (CNT_W'(r_best) < r_count), "selected view beyond stored entries")
    `CVS_ASSERT_NEXT(a_done_holds, (r_state == S_DONE) && r_out_valid && !i_m_axis_tready, r_state == S_DONE, "result dropped while output stalled")
endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the camera view selector top level.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cvs_pkg::*;

    localparam int  TABLE_SZ  = 1024;
    localparam int  SMALL_TAB = 48;
    localparam int  LIMIT     = 10_000_000;
    localparam int  U         = 65536;
    localparam logic [31:0] PMAX = 32'h7fff_ffff;
    localparam logic [31:0] PMIN = 32'h8000_0000;

    typedef logic signed [31:0] vec3_t [3];
    typedef struct packed {
        logic [9:0] view;
        logic [1:0] status;
    } view_res_t;
    typedef struct packed {
        logic        op;
        logic [31:0] ex, ey, ez, lx, ly, lz;
        logic        chk;
        logic [9:0]  view;
        logic [1:0]  status;
    } script_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [191:0] s_data = '0;
    logic [0:0]   s_op = '0;
    logic         m_ready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [30:0]  cfg_data = '0;
    wire          s_ready, m_valid, cfg_ready;
    wire  [15:0]  m_data;
    wire  [1:0]   m_status;

    camera_view_selector_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_op),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the block
    logic signed [31:0] cam_eye [TABLE_SZ][3];
    logic signed [31:0] cam_dir [TABLE_SZ][3];
    int unsigned        n_cams = 0;
    logic [9:0]         cur_view = START_RST;
    bit                 queried = 1'b0;
    logic [30:0]        radius = RADIUS_RST;
    logic [15:0]        cos_thr = COS_RST;

    view_res_t    pending_q[$];
    int unsigned  errors = 0;
    int unsigned  cycle = 0;
    logic signed [31:0] base_dir [3];

    task automatic report(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d expected %0d at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    function automatic logic [63:0] sq_dist(input vec3_t a, input vec3_t b);
        logic signed [32:0] d;
        logic [32:0]        m;
        logic [63:0]        sum;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d = 33'(a[k]) - 33'(b[k]);
            m = d[32] ? 33'(-d) : 33'(d);
            if (m > 33'h0_8000_0000) m = 33'h0_8000_0000;
            sum += 64'(m) * 64'(m);
        end
        return sum;
    endfunction

    // components shifted down together until all magnitudes are below 2^15
    function automatic logic [47:0] shrink(input vec3_t d);
        logic [31:0] mag [3];
        logic [31:0] mx;
        logic [47:0] o;
        mx = '0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = d[k] < 0 ? 32'(-33'(d[k])) : 32'(d[k]);
            if (mag[k] > mx) mx = mag[k];
        end
        while (mx >= 32'h8000) begin
            mx >>= 1;
            for (int k = 0; k < 3; k++) mag[k] >>= 1;
        end
        for (int k = 0; k < 3; k++)
            o[16*k +: 16] = d[k] < 0 ? 16'(-mag[k]) : 16'(mag[k]);
        return o;
    endfunction

    function automatic bit cos_ok(input logic [47:0] c, input logic [47:0] v);
        logic signed [63:0] dot, cc, vv, ck, vk;
        logic [127:0]       lhs, rhs;
        dot = 0; cc = 0; vv = 0;
        for (int k = 0; k < 3; k++) begin
            ck = 64'($signed(c[16*k +: 16]));
            vk = 64'($signed(v[16*k +: 16]));
            dot += ck * vk;
            cc  += ck * ck;
            vv  += vk * vk;
        end
        if (cc == 0 || vv == 0 || dot <= 0) return 1'b0;
        lhs = 128'(dot) * 128'(dot);
        lhs = lhs << 32;
        rhs = 128'(cc) * 128'(vv) * 128'(cos_thr) * 128'(cos_thr);
        return lhs > rhs;
    endfunction

    function automatic view_res_t predict_view(input logic op, input vec3_t eye,
                                               input vec3_t look);
        vec3_t              dir, ce, cn;
        logic signed [32:0] t;
        logic [63:0]        best_d, d, r2;
        logic [47:0]        vs;
        int unsigned        near, best;
        bit                 found;
        for (int k = 0; k < 3; k++) begin
            t = 33'(look[k]) - 33'(eye[k]);
            if (t > 33'sd2147483647) dir[k] = PMAX;
            else if (t < -33'sd2147483648) dir[k] = PMIN;
            else dir[k] = 32'(t);
        end
        if (op == OP_LOAD) begin
            if (n_cams >= TABLE_SZ) return '{10'd0, ST_FULL};
            for (int k = 0; k < 3; k++) begin
                cam_eye[n_cams][k] = eye[k];
                cam_dir[n_cams][k] = dir[k];
            end
            n_cams++;
            return '{10'(n_cams - 1), ST_OK};
        end
        queried = 1'b1;
        if (n_cams == 0) return '{cur_view, ST_EMPTY};
        near = 0;
        ce = cam_eye[0];
        best_d = sq_dist(eye, ce);
        for (int i = 1; i < n_cams; i++) begin
            ce = cam_eye[i];
            d = sq_dist(eye, ce);
            if (d < best_d) begin
                best_d = d;
                near = i;
            end
        end
        r2 = 64'(radius) * 64'(radius);
        vs = shrink(dir);
        cn = cam_eye[near];
        found = 1'b0;
        best = 0;
        for (int i = 0; i < n_cams; i++) begin
            ce = cam_eye[i];
            if (sq_dist(cn, ce) >= r2) continue;
            if (!cos_ok(shrink(cam_dir[i]), vs)) continue;
            d = sq_dist(eye, ce);
            if (!found || d < best_d) begin
                found = 1'b1;
                best_d = d;
                best = i;
            end
        end
        if (!found) return '{cur_view, ST_FALLBACK};
        cur_view = 10'(best);
        return '{cur_view, ST_OK};
    endfunction

    function automatic bit idle_now();
        return (cycle < 3000 || cycle >= 15000) && ($urandom_range(0, 99) < 26);
    endfunction

    task automatic send_pose(input logic op, input vec3_t eye, input vec3_t look,
                             input bit typed, input view_res_t want);
        view_res_t r;
        if (idle_now()) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_data  <= {look[2], look[1], look[0], eye[2], eye[1], eye[0]};
        do @(posedge i_clk); while (!s_ready);
        r = predict_view(op, eye, look);
        pending_q.push_back(typed ? want : r);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS: radius = val;
            CFG_COS:    cos_thr = val[15:0];
            CFG_START: begin
                if (!queried) cur_view = val[9:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // mostly clustered poses looking roughly along the phase direction
    task automatic random_pose(input logic op, output vec3_t eye, output vec3_t look);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        for (int k = 0; k < 3; k++) begin
            if (pick < 12) begin
                eye[k]  = $urandom();
                look[k] = $urandom();
            end else if (pick < 16) begin
                eye[k]  = $urandom_range(0, 1) ? PMAX : PMIN;
                look[k] = $urandom_range(0, 1) ? PMAX : PMIN;
            end else begin
                eye[k]  = $signed($urandom_range(0, 2400 * U)) - 1200 * U;
                look[k] = eye[k] + base_dir[k]
                        + ($signed($urandom_range(0, 200 * U)) - 100 * U);
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result view", m_data[9:0], -1);
            end else begin
                if (m_data[9:0] != pending_q[0].view)
                    report("view_index", m_data[9:0], pending_q[0].view);
                if (m_data[15:10] != 6'd0)
                    report("tdata fill", m_data[15:10], 0);
                if (m_status != pending_q[0].status)
                    report("status", m_status, pending_q[0].status);
                void'(pending_q.pop_front());
            end
        end
        m_ready <= !idle_now();
        if (cycle >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    script_row_t script [16] = '{
        '{OP_QUERY, 0, 0, 0, U, 0, 0, 1'b1, 10'd1023, ST_EMPTY},
        '{OP_LOAD, 0, 0, 0, U, 0, 0, 1'b1, 10'd0, ST_OK},
        '{OP_LOAD, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1'b1, 10'd1, ST_OK},
        '{OP_LOAD, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1'b1, 10'd2, ST_OK},
        '{OP_LOAD, 100 * U, 0, 0, 100 * U, 0, 0, 1'b1, 10'd3, ST_OK},
        '{OP_QUERY, 0, 0, 0, U, 0, 0, 1'b1, 10'd0, ST_OK},
        '{OP_QUERY, 0, 0, 0, -U, 0, 0, 1'b1, 10'd0, ST_FALLBACK},
        '{OP_QUERY, 0, 0, 0, 0, 0, 0, 1'b1, 10'd0, ST_FALLBACK},
        '{OP_QUERY, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1'b0, 10'd0, ST_OK},
        '{OP_QUERY, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1'b0, 10'd0, ST_OK},
        '{OP_LOAD, 1500 * U, 0, 0, 1501 * U, 0, 0, 1'b1, 10'd4, ST_OK},
        '{OP_LOAD, 1499 * U, 0, 0, 1500 * U, 0, 0, 1'b1, 10'd5, ST_OK},
        '{OP_LOAD, 0, 0, 0, 2 * U, 0, 0, 1'b1, 10'd6, ST_OK},
        '{OP_QUERY, 1000 * U, 0, 0, 1001 * U, 0, 0, 1'b0, 10'd0, ST_OK},
        '{OP_QUERY, U, 0, 0, 2 * U, 0, 0, 1'b0, 10'd0, ST_OK},
        '{OP_QUERY, 0, 0, 0, 0, U, 0, 1'b0, 10'd0, ST_OK}
    };

    initial begin
        vec3_t       eye, look;
        logic        op;
        logic [30:0] rad_set [6];
        logic [15:0] cos_set [6];
        logic [9:0]  view_set [6];
        rad_set  = '{31'd0, 31'h7fff_ffff, RADIUS_RST, 31'd0, 31'd0, 31'd0};
        cos_set  = '{16'd0, 16'hffff, COS_RST, 16'd0, 16'd0, 16'd0};
        view_set = '{10'd0, 10'd1023, START_RST, 10'd0, 10'd0, 10'd0};
        for (int p = 3; p < 6; p++) begin
            rad_set[p]  = 31'($urandom_range(200 * U, 3000 * U));
            cos_set[p]  = 16'($urandom_range(40000, 65535));
            view_set[p] = 10'($urandom_range(0, 1023));
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_START, 31'd1023);
        foreach (script[i]) begin
            eye  = '{script[i].ex, script[i].ey, script[i].ez};
            look = '{script[i].lx, script[i].ly, script[i].lz};
            send_pose(script[i].op, eye, look, script[i].chk,
                      '{script[i].view, script[i].status});
        end

        for (int p = 0; p < 6; p++) begin
            settle();
            write_reg(CFG_RADIUS, rad_set[p]);
            write_reg(CFG_COS, {15'd0, cos_set[p]});
            write_reg(CFG_START, {21'd0, view_set[p]});
            if (p == 2) write_reg(2'd3, 31'h7fff_ffff);
            for (int k = 0; k < 3; k++)
                base_dir[k] = $signed($urandom_range(0, 2000 * U)) - 1000 * U;
            for (int n = 0; n < 48; n++) begin
                op = (n_cams < SMALL_TAB && $urandom_range(0, 99) < 45) ? OP_LOAD : OP_QUERY;
                random_pose(op, eye, look);
                send_pose(op, eye, look, 1'b0, '0);
            end
        end

        // fill the table, overflow it, then query the full table
        settle();
        write_reg(CFG_RADIUS, 31'h7fff_ffff);
        write_reg(CFG_COS, 31'd0);
        while (n_cams < TABLE_SZ) begin
            random_pose(OP_LOAD, eye, look);
            send_pose(OP_LOAD, eye, look, 1'b0, '0);
        end
        random_pose(OP_LOAD, eye, look);
        send_pose(OP_LOAD, eye, look, 1'b1, '{10'd0, ST_FULL});
        for (int n = 0; n < 2; n++) begin
            random_pose(OP_QUERY, eye, look);
            send_pose(OP_QUERY, eye, look, 1'b0, '0);
        end
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
